// File: src/eabr_pkg.sv
package eabr_pkg;

    localparam int AngW        = 16;
    localparam int VecW        = 36;
    localparam int ZW          = 34;
    localparam int CordicSteps = 24;
    localparam int IterW       = 5;
    localparam int SqrtW       = 60;
    localparam int RootW       = 30;
    localparam int WeightW     = 9;

    localparam logic signed [VecW-1:0] CordicGain = 36'sd652032875;
    localparam logic signed [AngW-1:0] UnitQ14    = 16'sd16384;
    localparam logic signed [AngW-1:0] GimbalHigh = 16'sd16374;
    localparam logic signed [AngW-1:0] GimbalLow  = -16'sd16374;

    typedef struct packed {
        logic              command;
        logic signed [15:0] e00;
        logic signed [15:0] e10;
        logic signed [15:0] e20;
        logic signed [15:0] e01;
        logic signed [15:0] e11;
        logic signed [15:0] e21;
        logic signed [15:0] e22;
    } t_in;

    typedef struct packed {
        logic signed [15:0] o00;
        logic signed [15:0] o01;
        logic signed [15:0] o02;
        logic signed [15:0] o10;
        logic signed [15:0] o11;
        logic signed [15:0] o12;
        logic signed [15:0] o20;
        logic signed [15:0] o21;
        logic signed [15:0] o22;
    } t_out;

    typedef enum logic {
        CM_VEC = 1'b0,
        CM_ROT = 1'b1
    } t_cmode;

    typedef struct packed {
        t_cmode                 mode;
        logic signed [VecW-1:0] x;
        logic signed [VecW-1:0] y;
        logic signed [AngW-1:0] ang;
    } t_creq;

    typedef struct packed {
        logic                   busy;
        logic                   done;
        logic signed [AngW-1:0] ang;
        logic signed [AngW-1:0] sin;
        logic signed [AngW-1:0] cos;
    } t_cres;

    function automatic logic [31:0] atan_lut(input logic [IterW-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [AngW-1:0] clamp_unit(input logic signed [19:0] v);
        logic signed [AngW-1:0] r;
        if (v > 20'sd16384) begin
            r = UnitQ14;
        end else if (v < -20'sd16384) begin
            r = -UnitQ14;
        end else begin
            r = v[AngW-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/eabr_isqrt.sv
module eabr_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [eabr_pkg::SqrtW-1:0]  i_val,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [eabr_pkg::RootW-1:0]  o_root
);
    import eabr_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [SqrtW-1:0] r_v;
    logic [SqrtW-1:0] r_res;
    logic [SqrtW-1:0] r_bit;
    logic [SqrtW-1:0] w_trial;

    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // One result bit per cycle, starting from the highest even bit position.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_res <= '0;
            r_bit <= SqrtW'(1) << (SqrtW - 2);
        end else if (r_busy) begin
            if (r_v >= w_trial) begin
                r_v   <= r_v - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_res[RootW-1:0];

endmodule

// File: src/eabr_cordic.sv
module eabr_cordic (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  eabr_pkg::t_creq i_req,
    output eabr_pkg::t_cres o_res
);
    import eabr_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    t_cmode                 r_mode;
    logic                   r_zero;
    logic                   r_flip;
    logic [IterW-1:0]       r_i;
    logic signed [VecW-1:0] r_x;
    logic signed [VecW-1:0] r_y;
    logic signed [ZW-1:0]   r_z;

    logic signed [VecW-1:0] w_dx;
    logic signed [VecW-1:0] w_dy;
    logic signed [ZW-1:0]   w_at;
    logic                   w_pos;
    logic [31:0]            w_z0;
    logic                   w_flip0;
    logic [31:0]            w_zr;
    logic signed [VecW-1:0] w_xr;
    logic signed [VecW-1:0] w_yr;
    logic signed [19:0]     w_c;
    logic signed [19:0]     w_s;

    assign w_dx  = r_y >>> r_i;
    assign w_dy  = r_x >>> r_i;
    assign w_at  = ZW'(atan_lut(r_i));
    assign w_pos = (r_mode == CM_VEC) ? !r_y[VecW-1] : !r_z[ZW-1];

    assign w_flip0 = (i_req.ang > UnitQ14) || (i_req.ang < -UnitQ14);
    assign w_z0    = {i_req.ang, 16'h0000} + (w_flip0 ? 32'h8000_0000 : 32'h0000_0000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_i == IterW'(CordicSteps - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mode <= i_req.mode;
            r_i    <= '0;
            r_flip <= w_flip0;
            r_zero <= (i_req.x == '0) && (i_req.y == '0);
            if (i_req.mode == CM_ROT) begin
                r_x <= CordicGain;
                r_y <= '0;
                r_z <= ZW'($signed(w_z0));
            end else if (i_req.x[VecW-1]) begin
                // Left half-plane: turn the vector by half a turn first.
                r_x <= -i_req.x;
                r_y <= -i_req.y;
                r_z <= ZW'(33'h0_8000_0000);
            end else begin
                r_x <= i_req.x;
                r_y <= i_req.y;
                r_z <= '0;
            end
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (r_mode == CM_VEC) begin
                if (w_pos) begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_at;
                end else begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_at;
                end
            end else begin
                if (w_pos) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_at;
                end
            end
        end
    end

    assign w_zr = r_z[31:0] + 32'h0000_8000;
    assign w_xr = r_x + 36'sd32768;
    assign w_yr = r_y + 36'sd32768;
    assign w_c  = r_flip ? -w_xr[VecW-1:16] : w_xr[VecW-1:16];
    assign w_s  = r_flip ? -w_yr[VecW-1:16] : w_yr[VecW-1:16];

    always_comb begin
        o_res.busy = r_busy;
        o_res.done = r_done;
        o_res.ang  = r_zero ? '0 : $signed(w_zr[31:16]);
        o_res.cos  = clamp_unit(w_c);
        o_res.sin  = clamp_unit(w_s);
    end

endmodule

// File: src/euler_angle_blend_rotation.sv
// Z-Y-X Euler extraction and blend of rotation matrices.
//
// Input channel (i_in_valid / o_in_ready, i_in_data): one transaction holds a
// command and seven Q1.14 entries of a rotation matrix. A load command turns
// them into roll, pitch and yaw and keeps these as the reference; it produces
// no output. A fuse command blends the new angles with the reference at the
// weight held in register 0 (APB, byte address 0) and rebuilds the matrix.
// Output channel (o_out_valid / i_out_ready, o_out_data): nine Q1.14 entries.
//
// One item at a time runs through a single CORDIC unit, used up to six times
// (24 steps each), an integer square root of one bit per cycle and one shared
// multiplier. A load ends when o_in_ready returns; a fuse ends by raising
// o_out_valid. Under gimbal lock both skip the yaw step. o_in_ready is high
// only while the block is idle, so a new item is taken only once the previous
// one is through. A finished result waits in the output register; when the
// receiver stalls, the next item may still be accepted and worked on, and it
// waits only at the very end until the previous result has gone.
// Reset sets the weight to 205 and the reference to the identity orientation.
module euler_angle_blend_rotation (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  eabr_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output eabr_pkg::t_out o_out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import eabr_pkg::*;

    localparam logic [2:0] AddrWeight = 3'd0;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SQ     = 10'b00_0000_0010,
        S_SQRT   = 10'b00_0000_0100,
        S_PITCH  = 10'b00_0000_1000,
        S_YAW    = 10'b00_0001_0000,
        S_ROLL   = 10'b00_0010_0000,
        S_BLEND  = 10'b00_0100_0000,
        S_SINCOS = 10'b00_1000_0000,
        S_MAT    = 10'b01_0000_0000,
        S_OUT    = 10'b10_0000_0000
    } t_state;

    typedef enum logic [2:0] {
        AS_CY, AS_SY, AS_CP, AS_SP, AS_T1, AS_T2
    } t_asel;

    typedef enum logic [2:0] {
        BS_SP, BS_CP, BS_SR, BS_CR, BS_NEG
    } t_bsel;

    typedef enum logic [2:0] {
        MO_T1, MO_T2, MO_LOAD, MO_ADD, MO_SUB
    } t_mop;

    typedef struct packed {
        t_asel      a;
        t_bsel      b;
        t_mop       op;
        logic       sh;
        logic       fin;
        logic [3:0] idx;
    } t_mstep;

    // Product schedule for the rebuilt matrix yaw * pitch * roll.
    function automatic t_mstep mat_step(input logic [3:0] s);
        t_mstep m;
        unique case (s)
            4'd0:  m = '{AS_CY, BS_SP, MO_T1,   1'b0, 1'b0, 4'd0};
            4'd1:  m = '{AS_SY, BS_SP, MO_T2,   1'b0, 1'b0, 4'd0};
            4'd2:  m = '{AS_CY, BS_CP, MO_LOAD, 1'b1, 1'b1, 4'd0};
            4'd3:  m = '{AS_T1, BS_SR, MO_LOAD, 1'b0, 1'b0, 4'd0};
            4'd4:  m = '{AS_SY, BS_CR, MO_SUB,  1'b1, 1'b1, 4'd1};
            4'd5:  m = '{AS_T1, BS_CR, MO_LOAD, 1'b0, 1'b0, 4'd0};
            4'd6:  m = '{AS_SY, BS_SR, MO_ADD,  1'b1, 1'b1, 4'd2};
            4'd7:  m = '{AS_SY, BS_CP, MO_LOAD, 1'b1, 1'b1, 4'd3};
            4'd8:  m = '{AS_T2, BS_SR, MO_LOAD, 1'b0, 1'b0, 4'd0};
            4'd9:  m = '{AS_CY, BS_CR, MO_ADD,  1'b1, 1'b1, 4'd4};
            4'd10: m = '{AS_T2, BS_CR, MO_LOAD, 1'b0, 1'b0, 4'd0};
            4'd11: m = '{AS_CY, BS_SR, MO_SUB,  1'b1, 1'b1, 4'd5};
            4'd12: m = '{AS_SP, BS_NEG, MO_LOAD, 1'b1, 1'b1, 4'd6};
            4'd13: m = '{AS_CP, BS_SR, MO_LOAD, 1'b1, 1'b1, 4'd7};
            4'd14: m = '{AS_CP, BS_CR, MO_LOAD, 1'b1, 1'b1, 4'd8};
            default: m = '{AS_CY, BS_SP, MO_LOAD, 1'b0, 1'b0, 4'd0};
        endcase
        return m;
    endfunction

    t_state                 r_state;
    logic [3:0]             r_step;
    t_in                    r_in;
    logic [WeightW-1:0]     r_w;
    logic                   r_go;
    logic                   r_sq_go;
    logic                   r_neg;
    // Set when the pitch lies in the gimbal lock band of either sign.
    logic                   r_gim;
    logic [31:0]            r_sum;
    logic signed [15:0]     r_cur [3];
    logic signed [15:0]     r_ref [3];
    logic signed [15:0]     r_f   [3];
    logic signed [15:0]     r_s   [3];
    logic signed [15:0]     r_c   [3];
    logic signed [47:0]     r_prod;
    t_mstep                 r_dstep;
    logic signed [45:0]     r_acc;
    logic signed [30:0]     r_t1;
    logic signed [30:0]     r_t2;
    logic signed [15:0]     r_mat [9];
    logic signed [15:0]     r_bcur;
    logic [1:0]             r_bidx;
    t_out                   r_out;
    logic                   r_out_valid;

    logic                   w_cfg_wr;
    logic [WeightW-1:0]     w_wsat;
    logic [1:0]             w_k;
    t_creq                  w_req;
    t_cres                  w_cres;
    logic                   w_sq_busy;
    logic                   w_sq_done;
    logic [RootW-1:0]       w_root;
    logic signed [30:0]     w_ma;
    logic signed [16:0]     w_mb;
    logic signed [16:0]     w_diff;
    t_mstep                 w_mstep;
    logic signed [47:0]     w_bsum;
    logic signed [45:0]     w_term;
    logic signed [45:0]     w_acc_n;
    logic signed [45:0]     w_rnd;
    logic signed [15:0]     w_q;
    logic signed [15:0]     w_roll;
    logic                   w_gim_hi;
    logic                   w_gim_lo;
    logic                   w_in_acc;
    logic                   w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign pready     = 1'b1;
    assign prdata     = {23'd0, r_w};
    assign w_cfg_wr   = psel && penable && pwrite && (paddr == AddrWeight);
    assign w_wsat     = (r_w > 9'd256) ? 9'd256 : r_w;
    assign w_k        = (r_step[1:0] == 2'd3) ? 2'd0 : r_step[1:0];
    assign w_mstep    = mat_step(r_step);
    assign w_diff     = r_ref[w_k] - r_cur[w_k];
    assign w_gim_hi   = (w_cres.ang >= GimbalHigh);
    assign w_gim_lo   = (w_cres.ang <= GimbalLow);
    assign w_roll     = r_neg ? -w_cres.ang : w_cres.ang;

    eabr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_go),
        .i_val   ({r_sum, 28'd0}),
        .o_busy  (w_sq_busy),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    eabr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_req   (w_req),
        .o_res   (w_cres)
    );

    always_comb begin
        w_req.mode = CM_VEC;
        w_req.x    = '0;
        w_req.y    = '0;
        w_req.ang  = '0;
        priority case (1'b1)
            r_state[$clog2(S_PITCH)]: begin
                w_req.x = VecW'(w_root);
                w_req.y = -(VecW'(r_in.e20) <<< 14);
            end
            r_state[$clog2(S_YAW)]: begin
                w_req.x = VecW'(r_in.e00) <<< 14;
                w_req.y = VecW'(r_in.e10) <<< 14;
            end
            r_state[$clog2(S_ROLL)]: begin
                if (r_gim) begin
                    w_req.x = VecW'(r_in.e11) <<< 14;
                    w_req.y = VecW'(r_in.e01) <<< 14;
                end else begin
                    w_req.x = VecW'(r_in.e22) <<< 14;
                    w_req.y = VecW'(r_in.e21) <<< 14;
                end
            end
            r_state[$clog2(S_SINCOS)]: begin
                w_req.mode = CM_ROT;
                w_req.ang  = r_f[w_k];
            end
            default: begin
                w_req.mode = CM_VEC;
            end
        endcase
    end

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        priority case (1'b1)
            r_state[$clog2(S_SQ)]: begin
                w_ma = r_step[0] ? 31'(r_in.e10) : 31'(r_in.e00);
                w_mb = r_step[0] ? 17'(r_in.e10) : 17'(r_in.e00);
            end
            r_state[$clog2(S_BLEND)]: begin
                w_ma = 31'(w_diff);
                w_mb = $signed({8'd0, w_wsat});
            end
            r_state[$clog2(S_MAT)]: begin
                unique case (w_mstep.a)
                    AS_CY:   w_ma = 31'(r_c[2]);
                    AS_SY:   w_ma = 31'(r_s[2]);
                    AS_CP:   w_ma = 31'(r_c[1]);
                    AS_SP:   w_ma = 31'(r_s[1]);
                    AS_T1:   w_ma = r_t1;
                    AS_T2:   w_ma = r_t2;
                    default: w_ma = '0;
                endcase
                unique case (w_mstep.b)
                    BS_SP:   w_mb = 17'(r_s[1]);
                    BS_CP:   w_mb = 17'(r_c[1]);
                    BS_SR:   w_mb = 17'(r_s[0]);
                    BS_CR:   w_mb = 17'(r_c[0]);
                    BS_NEG:  w_mb = -17'sd16384;
                    default: w_mb = '0;
                endcase
            end
            default: begin
                w_ma = '0;
            end
        endcase
    end

    assign w_bsum = (48'(r_bcur) <<< 8) + r_prod + 48'sd128;
    assign w_term = r_dstep.sh ? (46'(r_prod) <<< 14) : 46'(r_prod);

    always_comb begin
        unique case (r_dstep.op)
            MO_ADD:  w_acc_n = r_acc + w_term;
            MO_SUB:  w_acc_n = r_acc - w_term;
            MO_LOAD: w_acc_n = w_term;
            default: w_acc_n = r_acc;
        endcase
    end

    assign w_rnd = w_acc_n + 46'sd134217728;
    assign w_q   = clamp_unit(20'($signed(w_rnd[45:28])));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_go        <= 1'b0;
            r_sq_go     <= 1'b0;
            r_neg       <= 1'b0;
            r_gim       <= 1'b0;
            r_out_valid <= 1'b0;
            r_w         <= 9'd205;
            r_ref[0]    <= '0;
            r_ref[1]    <= '0;
            r_ref[2]    <= '0;
        end else begin
            r_go    <= 1'b0;
            r_sq_go <= 1'b0;
            if (w_cfg_wr) begin
                r_w <= pwdata[WeightW-1:0];
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SQ;
                        r_step  <= '0;
                    end
                end
                S_SQ: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd2) begin
                        r_state <= S_SQRT;
                        r_sq_go <= 1'b1;
                    end
                end
                S_SQRT: begin
                    if (w_sq_done) begin
                        r_state <= S_PITCH;
                        r_go    <= 1'b1;
                    end
                end
                S_PITCH: begin
                    if (w_cres.done) begin
                        r_go  <= 1'b1;
                        r_neg <= w_gim_lo;
                        r_gim <= w_gim_hi || w_gim_lo;
                        if (w_gim_hi || w_gim_lo) begin
                            r_state <= S_ROLL;
                        end else begin
                            r_state <= S_YAW;
                        end
                    end
                end
                S_YAW: begin
                    if (w_cres.done) begin
                        r_state <= S_ROLL;
                        r_go    <= 1'b1;
                    end
                end
                S_ROLL: begin
                    if (w_cres.done) begin
                        if (!r_in.command) begin
                            r_ref[0] <= w_roll;
                            r_ref[1] <= r_cur[1];
                            r_ref[2] <= r_cur[2];
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_BLEND;
                            r_step  <= '0;
                        end
                    end
                end
                S_BLEND: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd3) begin
                        r_state <= S_SINCOS;
                        r_step  <= '0;
                        r_go    <= 1'b1;
                    end
                end
                S_SINCOS: begin
                    if (w_cres.done) begin
                        if (r_step == 4'd2) begin
                            r_state <= S_MAT;
                            r_step  <= '0;
                        end else begin
                            r_step <= r_step + 1'b1;
                            r_go   <= 1'b1;
                        end
                    end
                end
                S_MAT: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd15) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_data;
        end
        r_prod  <= w_ma * w_mb;
        r_dstep <= w_mstep;
        r_bcur  <= r_cur[w_k];
        r_bidx  <= w_k;
        if (r_state == S_SQ) begin
            if (r_step == 4'd1) begin
                r_sum <= r_prod[31:0];
            end else if (r_step == 4'd2) begin
                r_sum <= r_sum + r_prod[31:0];
            end
        end
        if ((r_state == S_PITCH) && w_cres.done) begin
            r_cur[1] <= w_cres.ang;
            r_cur[2] <= '0;
        end
        if ((r_state == S_YAW) && w_cres.done) begin
            r_cur[2] <= w_cres.ang;
        end
        if ((r_state == S_ROLL) && w_cres.done) begin
            r_cur[0] <= w_roll;
        end
        if ((r_state == S_BLEND) && (r_step != 4'd0)) begin
            r_f[r_bidx] <= w_bsum[23:8];
        end
        if ((r_state == S_SINCOS) && w_cres.done) begin
            r_s[w_k] <= w_cres.sin;
            r_c[w_k] <= w_cres.cos;
        end
        if ((r_state == S_MAT) && (r_step != 4'd0)) begin
            unique case (r_dstep.op)
                MO_T1:   r_t1 <= r_prod[30:0];
                MO_T2:   r_t2 <= r_prod[30:0];
                default: r_acc <= w_acc_n;
            endcase
            if (r_dstep.fin) begin
                r_mat[r_dstep.idx] <= w_q;
            end
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_out <= '{r_mat[0], r_mat[1], r_mat[2], r_mat[3], r_mat[4],
                       r_mat[5], r_mat[6], r_mat[7], r_mat[8]};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The shared units never run while the block is idle.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_cres.busy && !w_sq_busy))
        else $error("arithmetic unit busy while idle");

    a_cordic_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cres.done |-> ((r_state == S_PITCH) || (r_state == S_YAW) ||
                         (r_state == S_ROLL) || (r_state == S_SINCOS)))
        else $error("CORDIC result arrived outside an angle step");

    a_sqrt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_done |-> (r_state == S_SQRT))
        else $error("square root finished outside its step");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result presented without finishing the matrix");

endmodule
